/* design/pps_pkg.sv */
// Package for the projectile pitch solver: word types, side-band bundles
// and fixed constants (gravity, CORDIC angle table, output limits).
// Used by the channel interfaces, the top level and the testbench; depends on nothing.
`default_nettype none

package pps_pkg;

  // Gravity 9.7833 m/s^2 in Q16.
  localparam logic [19:0] GRAV_Q16 = 20'd641158;

  localparam int CORDIC_STEPS = 20;
  localparam int PITCH_LIMIT  = 25736;
  localparam logic [23:0] TIME_MAX = 24'hFFFFFF;

  // Arctangent of 2^-i in Q24 radians, rounded.
  localparam logic signed [26:0] ATAN_Q24 [CORDIC_STEPS] = '{
    27'sd13176795, 27'sd7778716, 27'sd4110060, 27'sd2086331, 27'sd1047214,
    27'sd524117,   27'sd262123,  27'sd131069,  27'sd65536,   27'sd32768,
    27'sd16384,    27'sd8192,    27'sd4096,    27'sd2048,    27'sd1024,
    27'sd512,      27'sd256,     27'sd128,     27'sd64,      27'sd32
  };

  // Input word: speed, distance and height, all Q8.8.
  typedef struct packed {
    logic [15:0]        muzzle_speed;
    logic [15:0]        horizontal_distance;
    logic signed [15:0] target_height;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic               solvable;
    logic signed [15:0] pitch_angle;
    logic [23:0]        flight_time;
  } out_word_t;

  // Values that ride along the discriminant square root.
  typedef struct packed {
    logic signed [55:0] q;
    logic [27:0]        w;
    logic [47:0]        gd2;
    logic [23:0]        gd;
    logic [15:0]        v;
    logic               bad;
  } sq1_side_t;

  // Values that ride along the tangent division.
  typedef struct packed {
    logic        qneg;
    logic [47:0] gd2;
    logic [23:0] gd;
    logic [15:0] v;
    logic        bad;
  } dv1_side_t;

  // Values that ride along the magnitude square root.
  typedef struct packed {
    logic signed [15:0] pitch;
    logic [15:0]        v;
    logic               bad;
  } sq2_side_t;

  // Values that ride along the flight time division.
  typedef struct packed {
    logic signed [15:0] pitch;
    logic               bad;
    logic               sat;
  } dv2_side_t;

endpackage

`default_nettype wire

/* design/pps_in_if.sv */
// Input channel of the projectile pitch solver: valid, ready and one word.
// Depends on pps_pkg for the word type.
`default_nettype none

interface pps_in_if;
  logic              valid;
  logic              ready;
  pps_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/pps_out_if.sv */
// Result channel of the projectile pitch solver: valid, ready and one word.
// Depends on pps_pkg for the word type.
`default_nettype none

interface pps_out_if;
  logic               valid;
  logic               ready;
  pps_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/pps_isqrt.sv */
// Pipelined integer square root, one result bit per stage, with side band.
// Stand-alone; the caller supplies the shared stage enable.
`default_nettype none

module pps_isqrt #(
  parameter int W  = 58,
  parameter int SW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            ce,
  input  logic            in_valid,
  input  logic [W-1:0]    rad,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [W/2-1:0]  root,
  output logic [SW-1:0]   out_side
);

  localparam int RW = W / 2;

  logic            vld_r  [0:RW-1];
  logic [W-1:0]    x_r    [0:RW-1];
  logic [RW+1:0]   rem_r  [0:RW-1];
  logic [RW-1:0]   rt_r   [0:RW-1];
  logic [SW-1:0]   sd_r   [0:RW-1];

  for (genvar k = 0; k < RW; k++) begin : g_step
    logic          v_in;
    logic [W-1:0]  x_in;
    logic [RW+1:0] rem_in;
    logic [RW-1:0] rt_in;
    logic [SW-1:0] sd_in;
    logic [RW+3:0] cur;
    logic [RW+3:0] trial;
    logic [RW+3:0] dif;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_in   = in_valid;
      assign x_in   = rad;
      assign rem_in = '0;
      assign rt_in  = '0;
      assign sd_in  = in_side;
    end else begin : g_next
      assign v_in   = vld_r[k-1];
      assign x_in   = x_r[k-1];
      assign rem_in = rem_r[k-1];
      assign rt_in  = rt_r[k-1];
      assign sd_in  = sd_r[k-1];
    end

    // Bring down the next two radicand bits and try the next root bit.
    assign cur   = {rem_in, x_in[W-1-2*k -: 2]};
    assign trial = {2'b00, rt_in, 2'b01};
    assign ge    = (cur >= trial);
    assign dif   = cur - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (ce) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        x_r[k]   <= x_in;
        sd_r[k]  <= sd_in;
        rem_r[k] <= ge ? dif[RW+1:0] : cur[RW+1:0];
        rt_r[k]  <= {rt_in[RW-2:0], ge};
      end
    end
  end

  assign out_valid = vld_r[RW-1];
  assign root      = rt_r[RW-1];
  assign out_side  = sd_r[RW-1];

endmodule

`default_nettype wire

/* design/pps_udiv.sv */
// Pipelined unsigned restoring divider, one quotient bit per stage.
// The caller guarantees that num / 2^QW is below den. Stand-alone.
`default_nettype none

module pps_udiv #(
  parameter int NW = 55,
  parameter int DW = 30,
  parameter int QW = 30,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          ce,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] out_side
);

  logic          vld_r [0:QW-1];
  logic [DW-1:0] rem_r [0:QW-1];
  logic [DW-1:0] den_r [0:QW-1];
  logic [QW-1:0] lo_r  [0:QW-1];
  logic [QW-1:0] qt_r  [0:QW-1];
  logic [SW-1:0] sd_r  [0:QW-1];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic          v_in;
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] lo_in;
    logic [QW-1:0] qt_in;
    logic [SW-1:0] sd_in;
    logic [DW:0]   cur;
    logic [DW:0]   dif;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = DW'(num[NW-1:QW]);
      assign den_in = den;
      assign lo_in  = num[QW-1:0];
      assign qt_in  = '0;
      assign sd_in  = in_side;
    end else begin : g_next
      assign v_in   = vld_r[k-1];
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign lo_in  = lo_r[k-1];
      assign qt_in  = qt_r[k-1];
      assign sd_in  = sd_r[k-1];
    end

    // Shift in the next numerator bit and subtract where it fits.
    assign cur = {rem_in, lo_in[QW-1]};
    assign ge  = (cur >= {1'b0, den_in});
    assign dif = cur - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (ce) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[k] <= ge ? dif[DW-1:0] : cur[DW-1:0];
        den_r[k] <= den_in;
        lo_r[k]  <= {lo_in[QW-2:0], 1'b0};
        qt_r[k]  <= {qt_in[QW-2:0], ge};
        sd_r[k]  <= sd_in;
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign quo       = qt_r[QW-1];
  assign out_side  = sd_r[QW-1];

endmodule

`default_nettype wire

/* design/projectile_pitch_solver.sv */
// Top level of the projectile pitch solver: drag-free launch angle and flight time.
// Depends on pps_pkg, pps_in_if, pps_out_if, pps_isqrt and pps_udiv.
//
//   channel  | role   | word
//   in_ch    | sink   | muzzle_speed, horizontal_distance, target_height
//   out_ch   | source | solvable, pitch_angle, flight_time
//
// One word enters per cycle while no result waits on out_ch. The pipeline
// is a chain of two square roots (29 and 31 stages), two dividers (30 and
// 24 stages), the 20-step CORDIC, ten arithmetic stages and the output
// register.
// Reset is synchronous and clears only the valid bits of the stages.
// The whole pipeline shares one enable: it holds while a result waits on out_ch.
`default_nettype none

module projectile_pitch_solver (
  input  logic      clk,
  input  logic      rst_n,
  pps_in_if.sink    in_ch,
  pps_out_if.source out_ch
);

  localparam int NSTEP = pps_pkg::CORDIC_STEPS;

  logic ce;
  logic out_vld_r;
  pps_pkg::out_word_t out_word_r;

  // Every stage advances unless a finished word is waiting downstream.
  assign ce          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = ce;

  // ---------------------------------------------------------------------
  // Stage 1: scale inputs: w = v^2, gd = g*d, |g*h|.
  logic [15:0] h_abs;
  logic [31:0] vsq;
  logic [35:0] g_d;
  logic [35:0] g_h;

  logic        s1_vld_r;
  logic        s1_bad_r;
  logic        s1_hneg_r;
  logic [15:0] s1_v_r;
  logic [27:0] s1_w_r;
  logic [23:0] s1_gd_r;
  logic [23:0] s1_ghm_r;

  assign h_abs = in_ch.data.target_height[15] ? 16'(-in_ch.data.target_height)
                                              : 16'(in_ch.data.target_height);
  assign vsq = 32'(in_ch.data.muzzle_speed) * 32'(in_ch.data.muzzle_speed);
  assign g_d = 36'(pps_pkg::GRAV_Q16) * 36'(in_ch.data.horizontal_distance);
  assign g_h = 36'(pps_pkg::GRAV_Q16) * 36'(h_abs);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (ce) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_bad_r  <= (in_ch.data.muzzle_speed == 16'd0) ||
                   (in_ch.data.horizontal_distance == 16'd0);
      s1_hneg_r <= in_ch.data.target_height[15];
      s1_v_r    <= in_ch.data.muzzle_speed;
      s1_w_r    <= vsq[31:4];
      s1_gd_r   <= g_d[35:12];
      s1_ghm_r  <= g_h[35:12];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: the three products of the quadratic.
  logic        s2_vld_r;
  logic        s2_bad_r;
  logic        s2_hneg_r;
  logic [15:0] s2_v_r;
  logic [27:0] s2_w_r;
  logic [23:0] s2_gd_r;
  logic [55:0] s2_wsq_r;
  logic [47:0] s2_gd2_r;
  logic [51:0] s2_ghw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (ce) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s2_bad_r  <= s1_bad_r;
      s2_hneg_r <= s1_hneg_r;
      s2_v_r    <= s1_v_r;
      s2_w_r    <= s1_w_r;
      s2_gd_r   <= s1_gd_r;
      s2_wsq_r  <= 56'(s1_w_r) * 56'(s1_w_r);
      s2_gd2_r  <= 48'(s1_gd_r) * 48'(s1_gd_r);
      s2_ghw_r  <= 52'(s1_ghm_r) * 52'(s1_w_r);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: q = gd^2 + 2*gh*w.
  logic [52:0]        ghw2;
  logic signed [55:0] q_nxt;

  logic               s3_vld_r;
  logic               s3_bad_r;
  logic [15:0]        s3_v_r;
  logic [27:0]        s3_w_r;
  logic [23:0]        s3_gd_r;
  logic [47:0]        s3_gd2_r;
  logic [55:0]        s3_wsq_r;
  logic signed [55:0] s3_q_r;

  assign ghw2  = {s2_ghw_r, 1'b0};
  assign q_nxt = s2_hneg_r ? $signed(56'(s2_gd2_r) - 56'(ghw2))
                           : $signed(56'(s2_gd2_r) + 56'(ghw2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (ce) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s3_bad_r <= s2_bad_r;
      s3_v_r   <= s2_v_r;
      s3_w_r   <= s2_w_r;
      s3_gd_r  <= s2_gd_r;
      s3_gd2_r <= s2_gd2_r;
      s3_wsq_r <= s2_wsq_r;
      s3_q_r   <= q_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: discriminant; a negative one marks the word unsolvable.
  logic signed [57:0] disc_nxt;

  logic               s4_vld_r;
  logic [57:0]        s4_rad_r;
  pps_pkg::sq1_side_t s4_side_r;

  assign disc_nxt = $signed({2'b00, s3_wsq_r}) - 58'(s3_q_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (ce) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s4_rad_r      <= disc_nxt[57] ? 58'd0 : 58'(disc_nxt);
      s4_side_r.q   <= s3_q_r;
      s4_side_r.w   <= s3_w_r;
      s4_side_r.gd2 <= s3_gd2_r;
      s4_side_r.gd  <= s3_gd_r;
      s4_side_r.v   <= s3_v_r;
      s4_side_r.bad <= s3_bad_r || disc_nxt[57];
    end
  end

  // Square root of the discriminant.
  logic               sq1_vld;
  logic [28:0]        sq1_s;
  pps_pkg::sq1_side_t sq1_side;

  pps_isqrt #(
    .W  (58),
    .SW ($bits(pps_pkg::sq1_side_t))
  ) u_sqrt_disc (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (s4_vld_r),
    .rad       (s4_rad_r),
    .in_side   (s4_side_r),
    .out_valid (sq1_vld),
    .root      (sq1_s),
    .out_side  (sq1_side)
  );

  // ---------------------------------------------------------------------
  // Stage 5: n = q / (w + s), rounded half away from zero, as a magnitude.
  logic [29:0] den_nxt;
  logic [54:0] qa_nxt;

  logic               s5_vld_r;
  logic [54:0]        s5_num_r;
  logic [29:0]        s5_den_r;
  pps_pkg::dv1_side_t s5_side_r;

  assign den_nxt = 30'(sq1_side.w) + 30'(sq1_s);
  assign qa_nxt  = sq1_side.q[55] ? 55'(-sq1_side.q) : 55'(sq1_side.q);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (ce) begin
      s5_vld_r <= sq1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s5_num_r       <= qa_nxt + 55'(den_nxt[29:1]);
      s5_den_r       <= den_nxt;
      s5_side_r.qneg <= sq1_side.q[55];
      s5_side_r.gd2  <= sq1_side.gd2;
      s5_side_r.gd   <= sq1_side.gd;
      s5_side_r.v    <= sq1_side.v;
      s5_side_r.bad  <= sq1_side.bad || (den_nxt == 30'd0);
    end
  end

  logic               dv1_vld;
  logic [29:0]        dv1_nm;
  pps_pkg::dv1_side_t dv1_side;

  pps_udiv #(
    .NW (55),
    .DW (30),
    .QW (30),
    .SW ($bits(pps_pkg::dv1_side_t))
  ) u_div_tan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (s5_vld_r),
    .num       (s5_num_r),
    .den       (s5_den_r),
    .in_side   (s5_side_r),
    .out_valid (dv1_vld),
    .quo       (dv1_nm),
    .out_side  (dv1_side)
  );

  // ---------------------------------------------------------------------
  // Stage 6: signed n and n^2.
  logic               s6_vld_r;
  logic               s6_bad_r;
  logic [15:0]        s6_v_r;
  logic [23:0]        s6_gd_r;
  logic [47:0]        s6_gd2_r;
  logic signed [30:0] s6_n_r;
  logic [59:0]        s6_n2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else if (ce) begin
      s6_vld_r <= dv1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s6_bad_r <= dv1_side.bad;
      s6_v_r   <= dv1_side.v;
      s6_gd_r  <= dv1_side.gd;
      s6_gd2_r <= dv1_side.gd2;
      s6_n_r   <= dv1_side.qneg ? -$signed(31'(dv1_nm)) : $signed(31'(dv1_nm));
      s6_n2_r  <= 60'(dv1_nm) * 60'(dv1_nm);
    end
  end

  // ---------------------------------------------------------------------
  // CORDIC vectoring on (gd, n); entry stage also forms gd^2 + n^2.
  logic               cvld_r  [0:NSTEP];
  logic               cbad_r  [0:NSTEP];
  logic [15:0]        cv_r    [0:NSTEP];
  logic [61:0]        crad_r  [0:NSTEP];
  logic signed [33:0] cx_r    [0:NSTEP];
  logic signed [33:0] cy_r    [0:NSTEP];
  logic signed [26:0] cz_r    [0:NSTEP];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cvld_r[0] <= 1'b0;
    end else if (ce) begin
      cvld_r[0] <= s6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      cbad_r[0] <= s6_bad_r;
      cv_r[0]   <= s6_v_r;
      crad_r[0] <= 62'(s6_gd2_r) + 62'(s6_n2_r);
      cx_r[0]   <= $signed(34'(s6_gd_r));
      cy_r[0]   <= 34'(s6_n_r);
      cz_r[0]   <= '0;
    end
  end

  for (genvar i = 0; i < NSTEP; i++) begin : g_cordic
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic               up;

    assign dx = cy_r[i] >>> i;
    assign dy = cx_r[i] >>> i;
    assign up = (cy_r[i] > 34'sd0);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cvld_r[i+1] <= 1'b0;
      end else if (ce) begin
        cvld_r[i+1] <= cvld_r[i];
      end
    end

    // Rotate toward the x axis and accumulate the angle.
    always_ff @(posedge clk) begin
      if (ce) begin
        cbad_r[i+1] <= cbad_r[i];
        cv_r[i+1]   <= cv_r[i];
        crad_r[i+1] <= crad_r[i];
        cx_r[i+1]   <= up ? cx_r[i] + dx : cx_r[i] - dx;
        cy_r[i+1]   <= up ? cy_r[i] - dy : cy_r[i] + dy;
        cz_r[i+1]   <= up ? cz_r[i] + pps_pkg::ATAN_Q24[i]
                          : cz_r[i] - pps_pkg::ATAN_Q24[i];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Pitch stage: round Q24 angle to Q14 and clamp.
  logic signed [27:0] z_rnd;
  logic signed [27:0] z_sh;
  logic signed [15:0] pitch_nxt;

  logic               p_vld_r;
  logic [61:0]        p_rad_r;
  pps_pkg::sq2_side_t p_side_r;

  assign z_rnd = 28'(cz_r[NSTEP]) + 28'sd512;
  assign z_sh  = z_rnd >>> 10;

  always_comb begin
    if (z_sh > 28'(pps_pkg::PITCH_LIMIT)) begin
      pitch_nxt = 16'(pps_pkg::PITCH_LIMIT);
    end else if (z_sh < -28'(pps_pkg::PITCH_LIMIT)) begin
      pitch_nxt = -16'(pps_pkg::PITCH_LIMIT);
    end else begin
      pitch_nxt = 16'(z_sh);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (ce) begin
      p_vld_r <= cvld_r[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      p_rad_r        <= crad_r[NSTEP];
      p_side_r.pitch <= pitch_nxt;
      p_side_r.v     <= cv_r[NSTEP];
      p_side_r.bad   <= cbad_r[NSTEP];
    end
  end

  // Magnitude sqrt(gd^2 + n^2).
  logic               sq2_vld;
  logic [30:0]        sq2_mag;
  pps_pkg::sq2_side_t sq2_side;

  pps_isqrt #(
    .W  (62),
    .SW ($bits(pps_pkg::sq2_side_t))
  ) u_sqrt_mag (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (p_vld_r),
    .rad       (p_rad_r),
    .in_side   (p_side_r),
    .out_valid (sq2_vld),
    .root      (sq2_mag),
    .out_side  (sq2_side)
  );

  // ---------------------------------------------------------------------
  // Stage G: g*v.
  logic               g_vld_r;
  logic [35:0]        g_gv_r;
  logic [30:0]        g_mag_r;
  logic signed [15:0] g_pitch_r;
  logic               g_bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
    end else if (ce) begin
      g_vld_r <= sq2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      g_gv_r    <= 36'(pps_pkg::GRAV_Q16) * 36'(sq2_side.v);
      g_mag_r   <= sq2_mag;
      g_pitch_r <= sq2_side.pitch;
      g_bad_r   <= sq2_side.bad;
    end
  end

  // ---------------------------------------------------------------------
  // Stage N: rounded numerator for the flight time and the saturation test.
  logic [59:0] tnum_nxt;

  logic               n_vld_r;
  logic [59:0]        n_num_r;
  logic [35:0]        n_gv_r;
  pps_pkg::dv2_side_t n_side_r;

  assign tnum_nxt = 60'({g_mag_r, 28'd0}) + 60'(g_gv_r[35:1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_vld_r <= 1'b0;
    end else if (ce) begin
      n_vld_r <= g_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      n_num_r        <= tnum_nxt;
      n_gv_r         <= g_gv_r;
      n_side_r.pitch <= g_pitch_r;
      n_side_r.bad   <= g_bad_r;
      n_side_r.sat   <= (tnum_nxt[59:24] >= g_gv_r);
    end
  end

  logic               dv2_vld;
  logic [23:0]        dv2_t;
  pps_pkg::dv2_side_t dv2_side;

  pps_udiv #(
    .NW (60),
    .DW (36),
    .QW (24),
    .SW ($bits(pps_pkg::dv2_side_t))
  ) u_div_time (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (n_vld_r),
    .num       (n_num_r),
    .den       (n_gv_r),
    .in_side   (n_side_r),
    .out_valid (dv2_vld),
    .quo       (dv2_t),
    .out_side  (dv2_side)
  );

  // ---------------------------------------------------------------------
  // Output register: unsolvable words report zeros.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (ce) begin
      out_vld_r <= dv2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_word_r.solvable    <= !dv2_side.bad;
      out_word_r.pitch_angle <= dv2_side.bad ? 16'sd0 : dv2_side.pitch;
      out_word_r.flight_time <= dv2_side.bad ? 24'd0 :
                                dv2_side.sat ? pps_pkg::TIME_MAX : dv2_t;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_word_r;

  // ---------------------------------------------------------------------
  // Checks on the block's own logic.
  a_unsolvable_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.data.solvable) |->
      (out_ch.data.pitch_angle == 16'sd0 && out_ch.data.flight_time == 24'd0))
    else $error("unsolvable word carries a nonzero angle or time");

  a_pitch_range : assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.solvable) |->
      (out_ch.data.pitch_angle <= 16'sd25736 && out_ch.data.pitch_angle >= -16'sd25736))
    else $error("pitch angle outside its clamp range");

  a_stall_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while the pipeline is stalled");

endmodule

`default_nettype wire

/* dv/pps_tb_if.sv */
// Testbench copy note: the block's channel interfaces live in the design folder.
// This file holds nothing but a shared stall-length helper package for the bench.
// Depends on nothing.
`timescale 1ns / 1ps

package pps_tb_pkg;
  // Longest hold-off of the result side during the fill test, in cycles.
  localparam int LONG_HOLD = 400;
endpackage

/* dv/projectile_pitch_solver_tb.sv */
// Testbench for projectile_pitch_solver: drives aiming queries and checks each
// result word against a bit-exact predictor of the fixed-point solver.
// Depends on pps_pkg, pps_in_if, pps_out_if, pps_tb_pkg and the block's RTL.
`timescale 1ns / 1ps

module projectile_pitch_solver_tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pps_in_if  in_ch ();
  pps_out_if out_ch ();

  projectile_pitch_solver u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #5 clk = ~clk;

  pps_pkg::out_word_t aim_q[$];
  int                 errors = 0;
  bit                 hold_out = 1'b0;
  bit                 ready_idle = 1'b1;

  // Floor square root of an unsigned 64-bit value.
  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Arithmetic shift right that rounds toward minus infinity.
  function automatic longint shr_floor(longint v, int k);
    return v >>> k;
  endfunction

  // Expected firing solution for one query.
  function automatic pps_pkg::out_word_t solve_aim(pps_pkg::in_word_t q_in);
    pps_pkg::out_word_t res;
    longint          w, gd, gh, q, disc, s, den, n, pitch, x, y, z, dx, dy;
    longint unsigned ghm, qa, nm, mag, gv, t, vr, dr, ha;
    res = '0;
    vr = 64'(q_in.muzzle_speed);
    dr = 64'(q_in.horizontal_distance);
    if (vr == 0 || dr == 0) return res;
    w = longint'((vr * vr) >> 4);
    gd = longint'((64'(pps_pkg::GRAV_Q16) * dr) >> 12);
    ha = (q_in.target_height < 0) ? longint'(-int'(q_in.target_height))
                                  : longint'(q_in.target_height);
    ghm = (64'(pps_pkg::GRAV_Q16) * ha) >> 12;
    gh = (q_in.target_height < 0) ? -longint'(ghm) : longint'(ghm);
    q = gd * gd + 2 * gh * w;
    disc = w * w - q;
    if (disc < 0) return res;
    s = longint'(root_floor(disc));
    den = w + s;
    if (den <= 0 || gd <= 0) return res;
    qa = (q < 0) ? -q : q;
    nm = (qa + den / 2) / den;
    n = (q < 0) ? -longint'(nm) : longint'(nm);
    // CORDIC vectoring on (gd, n).
    x = gd;
    y = n;
    z = 0;
    for (int i = 0; i < pps_pkg::CORDIC_STEPS; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (y > 0) begin
        x += dx;
        y -= dy;
        z += longint'(pps_pkg::ATAN_Q24[i]);
      end else begin
        x -= dx;
        y += dy;
        z -= longint'(pps_pkg::ATAN_Q24[i]);
      end
    end
    pitch = shr_floor(z + 512, 10);
    if (pitch > pps_pkg::PITCH_LIMIT) pitch = longint'(pps_pkg::PITCH_LIMIT);
    if (pitch < -pps_pkg::PITCH_LIMIT) pitch = -longint'(pps_pkg::PITCH_LIMIT);
    mag = root_floor(gd * gd + n * n);
    gv = 64'(pps_pkg::GRAV_Q16) * vr;
    t = ((mag << 28) + gv / 2) / gv;
    if (t > pps_pkg::TIME_MAX) t = 64'(pps_pkg::TIME_MAX);
    res.solvable = 1'b1;
    res.pitch_angle = pitch[15:0];
    res.flight_time = t[23:0];
    return res;
  endfunction

  // Sends one query word after an optional random gap and records its expectation.
  task automatic send_query(logic [15:0] v, logic [15:0] d, logic [15:0] h,
                            bit gaps = 1'b1);
    pps_pkg::in_word_t wd;
    int                gap;
    wd.muzzle_speed = v;
    wd.horizontal_distance = d;
    wd.target_height = h;
    gap = gaps ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14)) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= wd;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    aim_q.push_back(solve_aim(wd));
    @(negedge clk);
  endtask

  task automatic end_burst();
    in_ch.valid <= 1'b0;
  endtask

  // Waits until every expected word has arrived, or until its guard runs out.
  task automatic drain();
    int guard;
    guard = 0;
    while (aim_q.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
  endtask

  // Random query biased toward solvable geometry.
  task automatic send_random(bit gaps = 1'b1);
    logic [15:0] v, d, h;
    case ($urandom_range(0, 5))
      0: begin
        v = 16'($urandom);
        d = 16'($urandom);
        h = 16'($urandom);
      end
      1: begin
        v = 16'($urandom_range(16'h0800, 16'hFFFF));
        d = 16'($urandom_range(1, 16'h0400));
        h = 16'($urandom_range(0, 16'hFFFF));
      end
      2: begin
        v = 16'($urandom_range(1, 16'h00FF));
        d = 16'($urandom_range(1, 16'h00FF));
        h = 16'($signed($urandom_range(0, 512)) - 256);
      end
      default: begin
        v = 16'($urandom_range(16'h0C00, 16'h7FFF));
        d = 16'($urandom_range(1, 16'h4000));
        h = 16'($signed($urandom_range(0, 16'h2000)) - 16'sh1000);
      end
    endcase
    send_query(v, d, h, gaps);
  endtask

  // Directed corners: zero speed, zero distance, field extremes, no solution.
  task automatic test_corners();
    send_query(16'h0000, 16'h1000, 16'h0000);
    send_query(16'h1000, 16'h0000, 16'h0000);
    send_query(16'h0000, 16'h0000, 16'h8000);
    send_query(16'hFFFF, 16'hFFFF, 16'h7FFF);
    send_query(16'hFFFF, 16'hFFFF, 16'h8000);
    send_query(16'hFFFF, 16'h0001, 16'h0000);
    send_query(16'h0001, 16'h0001, 16'h0000);
    send_query(16'h0001, 16'hFFFF, 16'h8000);
    send_query(16'h0100, 16'hFFFF, 16'h0000);
    send_query(16'h1400, 16'h0A00, 16'h0000);
    send_query(16'h1400, 16'h0A00, 16'h0500);
    send_query(16'h1400, 16'h0A00, 16'hFB00);
    send_query(16'h1400, 16'h0001, 16'h7FFF);
    send_query(16'h1400, 16'h0001, 16'h8000);
    send_query(16'hFFFF, 16'h0001, 16'h7FFF);
    send_query(16'h0200, 16'h0200, 16'h0100);
    send_query(16'h5555, 16'hAAAA, 16'h5555);
    send_query(16'hAAAA, 16'h5555, 16'hAAAA);
    end_burst();
    drain();
  endtask

  // Random traffic with idling on both sides.
  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_random();
    end_burst();
  endtask

  // Back-to-back traffic against a stalled result side, so the pipe fills.
  task automatic test_fill();
    hold_out = 1'b1;
    for (int i = 0; i < 300; i++) send_random(1'b0);
    end_burst();
    wait (hold_out == 1'b0);
    drain();
  endtask

  // Result-side ready: random stalls, or a long hold-off while requested.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_ch.ready <= 1'b0;
        repeat (pps_tb_pkg::LONG_HOLD) @(negedge clk);
        hold_out = 1'b0;
      end else if (ready_idle && $urandom_range(0, 3) != 0) begin
        stall = $urandom_range(0, 14);
        if (stall != 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
        out_ch.ready <= 1'b1;
        @(posedge clk);
        while (!out_ch.valid) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Compares each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    pps_pkg::out_word_t exp_w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (aim_q.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_ch.data);
        errors++;
      end else begin
        exp_w = aim_q.pop_front();
        if (exp_w.solvable !== out_ch.data.solvable) begin
          $display("%0t: solvable expected %0d actual %0d", $time,
                   exp_w.solvable, out_ch.data.solvable);
          errors++;
        end
        if (exp_w.pitch_angle !== out_ch.data.pitch_angle) begin
          $display("%0t: pitch_angle expected %0d actual %0d", $time,
                   exp_w.pitch_angle, out_ch.data.pitch_angle);
          errors++;
        end
        if (exp_w.flight_time !== out_ch.data.flight_time) begin
          $display("%0t: flight_time expected %0d actual %0d", $time,
                   exp_w.flight_time, out_ch.data.flight_time);
          errors++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_corners();
    test_random(700);
    drain();
    test_fill();
    test_random(800);
    drain();
    repeat (200) @(negedge clk);
    if (errors == 0 && aim_q.size() == 0) begin
      $display("PASS projectile_pitch_solver");
    end else begin
      if (aim_q.size() != 0) $display("%0t: %0d words never arrived", $time, aim_q.size());
      $display("FAIL projectile_pitch_solver");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5ms;
    $display("FAIL projectile_pitch_solver");
    $finish;
  end

endmodule
